>>> hdl/hff_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and character constants for the hex float formatter.
// No dependencies.
package hff_pkg;

  localparam int VALUE_W    = 64;
  localparam int FRAC_W     = 52;
  localparam int EXPF_W     = 11;
  localparam int SIG_W      = FRAC_W + 2;
  localparam int FRAC_NIBS  = FRAC_W / 4;
  localparam int EXP_W      = 12;
  localparam int MAG_W      = 11;
  localparam int BCD_W      = 16;
  localparam int EXP_BIAS   = 1023;
  localparam int PREC_W     = 7;
  localparam int SPACE_W    = 8;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int MAX_ITEMS  = 48;
  localparam int ROUND_NIBS = 13;
  localparam int DEF_MAX_PRECISION = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_CASE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILING_POINT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_CHAR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT_LETTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_EXP_DIGITS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUS_SIGN       = 3'd6;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_LETTER  = 8'h70;

  typedef struct packed {
    logic              upper_case;
    logic              normalize_mode;
    logic              trailing_point;
    logic [CHAR_W-1:0] point_char;
    logic [CHAR_W-1:0] exponent_letter;
    logic [2:0]        min_exp_digits;
    logic              plus_sign;
  } hff_cfg_t;

  typedef struct packed {
    logic load;
    logic norm_step;
    logic fix;
    logic nib_shift;
    logic exp_inc;
    logic dabble_start;
    logic dabble_step;
  } hff_ctl_t;

  typedef struct packed {
    logic       lead_set;
    logic [3:0] lead_nib;
    logic [3:0] top_nib;
    logic [3:0] scan_nib;
    logic       carry;
  } hff_frac_st_t;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
    logic [2:0]       ndig;
  } hff_exp_st_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (nib < 4'd10) hex_char = CH_ZERO + {4'b0, nib};
    else hex_char = base + {4'b0, nib} - 8'd10;
  endfunction

endpackage

>>> hdl/hff_in_if.sv
`timescale 1ns / 1ps
// Input channel: binary64 pattern, hex precision and room, valid/ready.
// Depends on hff_pkg.
interface hff_in_if import hff_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [VALUE_W-1:0]        value_bits;
  logic signed [PREC_W-1:0]  hex_precision;
  logic [SPACE_W-1:0]        space_available;

  modport source (output valid, output value_bits, output hex_precision,
                  output space_available, input ready);
  modport sink (input valid, input value_bits, input hex_precision,
                input space_available, output ready);
endinterface

>>> hdl/hff_out_if.sv
`timescale 1ns / 1ps
// Result channel: one text character per item, valid/ready.
// Depends on hff_pkg.
interface hff_out_if import hff_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;
  logic              no_room;

  modport source (output valid, output out_char, output last_char,
                  output no_room, input ready);
  modport sink (input valid, input out_char, input last_char,
                input no_room, output ready);
endinterface

>>> hdl/hff_frac_unit.sv
`timescale 1ns / 1ps
// Significand register: load, one-bit normalize shifts, rounding at the
// precision, nibble scan and nibble-serial shift-out. Depends on hff_pkg.
module hff_frac_unit import hff_pkg::*; (
  input  logic                     clk,
  input  hff_ctl_t                 ctl,
  input  logic [VALUE_W-1:0]       value_bits,
  input  logic                     normalize_mode,
  input  logic signed [PREC_W-1:0] prec,
  input  logic [3:0]               scan_idx,
  output hff_frac_st_t             st
);

  logic [SIG_W-1:0]  sig_r, sig_nxt;
  logic [EXPF_W-1:0] expf;
  logic [FRAC_W-1:0] frac_in;
  logic [SIG_W-1:0]  base, rbit, sum;
  logic [5:0]        cut;
  logic              round_en, half;
  logic [3:0]        nib_a [FRAC_NIBS];

  assign expf    = value_bits[FRAC_W+EXPF_W-1:FRAC_W];
  assign frac_in = value_bits[FRAC_W-1:0];

  assign base     = normalize_mode ? {2'b00, sig_r[FRAC_W-1:0]} : sig_r;
  assign round_en = !prec[PREC_W-1] && (prec[5:0] < 6'(ROUND_NIBS));
  assign cut      = 6'(FRAC_W-1) - {prec[3:0], 2'b00};
  assign rbit     = SIG_W'(1) << (cut + 6'd1);
  assign half     = base[cut];
  assign sum      = base + (half ? rbit : '0);

  always_comb begin
    for (int i = 0; i < FRAC_NIBS; i++) begin
      nib_a[i] = sig_r[FRAC_W-1-4*i -: 4];
    end
  end

  always_comb begin
    sig_nxt = sig_r;
    if (ctl.load) begin
      if (expf == '0 && frac_in == '0) sig_nxt = '0;
      else if (normalize_mode) sig_nxt = {2'b00, frac_in};
      else sig_nxt = {1'b0, expf != '0, frac_in};
    end else if (ctl.norm_step) begin
      sig_nxt = {sig_r[SIG_W-2:0], 1'b0};
    end else if (ctl.fix) begin
      sig_nxt = round_en ? (sum & ~(rbit - SIG_W'(1))) : base;
    end else if (ctl.nib_shift) begin
      sig_nxt = {sig_r[SIG_W-1:FRAC_W], sig_r[FRAC_W-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk) begin
    sig_r <= sig_nxt;
  end

  assign st.lead_set = sig_r[FRAC_W];
  assign st.lead_nib = {2'b00, sig_r[SIG_W-1:FRAC_W]};
  assign st.top_nib  = sig_r[FRAC_W-1:FRAC_W-4];
  assign st.scan_nib = nib_a[scan_idx];
  assign st.carry    = normalize_mode && round_en && half && sum[FRAC_W];

endmodule

>>> hdl/hff_exp_unit.sv
`timescale 1ns / 1ps
// Binary exponent register and bit-serial binary to BCD conversion
// (shift and add three). Depends on hff_pkg.
module hff_exp_unit import hff_pkg::*; (
  input  logic               clk,
  input  hff_ctl_t           ctl,
  input  logic [VALUE_W-1:0] value_bits,
  output hff_exp_st_t        st
);

  logic [EXP_W-1:0]  e_r, e_nxt;
  logic [MAG_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt, adj;
  logic [EXPF_W-1:0] expf;
  logic [EXP_W-1:0]  mag;

  assign expf = value_bits[FRAC_W+EXPF_W-1:FRAC_W];
  assign mag  = e_r[EXP_W-1] ? (~e_r + EXP_W'(1)) : e_r;

  always_comb begin
    for (int d = 0; d < BCD_W / 4; d++) begin
      adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3 : bcd_r[4*d +: 4];
    end
  end

  always_comb begin
    e_nxt   = e_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctl.load) begin
      if (value_bits[FRAC_W+EXPF_W-1:0] == '0) e_nxt = '0;
      else e_nxt = EXP_W'({1'b0, expf}) - EXP_W'(EXP_BIAS) + EXP_W'(expf == '0);
    end else if (ctl.norm_step) begin
      e_nxt = e_r - EXP_W'(1);
    end else if (ctl.exp_inc) begin
      e_nxt = e_r + EXP_W'(1);
    end
    if (ctl.dabble_start) begin
      bin_nxt = mag[MAG_W-1:0];
      bcd_nxt = '0;
    end else if (ctl.dabble_step) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[MAG_W-1]};
      bin_nxt = {bin_r[MAG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign st.neg  = e_r[EXP_W-1];
  assign st.bcd  = bcd_r;
  assign st.ndig = (bcd_r[15:12] != '0) ? 3'd4 :
                   (bcd_r[11:8] != '0)  ? 3'd3 :
                   (bcd_r[7:4] != '0)   ? 3'd2 : 3'd1;

endmodule

>>> hdl/hff_seq.sv
`timescale 1ns / 1ps
// Sequencer: steps the significand and exponent units, sizes the text and emits it
// via an output register, one character per cycle unless stalled. Depends on hff_pkg.
module hff_seq import hff_pkg::*; #(
  parameter int MAX_PRECISION = DEF_MAX_PRECISION
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hff_cfg_t                 cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [VALUE_W-1:0]       value_bits,
  input  logic signed [PREC_W-1:0] hex_precision,
  input  logic [SPACE_W-1:0]       space_available,
  output hff_ctl_t                 ctl,
  output logic signed [PREC_W-1:0] prec,
  output logic [3:0]               scan_idx,
  input  hff_frac_st_t             frac_st,
  input  hff_exp_st_t              exp_st,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CHAR_W-1:0]        out_char,
  output logic                     last_char,
  output logic                     no_room
);

  localparam int FW_W  = $clog2(MAX_PRECISION + 1);
  localparam int LEN_W = $clog2(MAX_PRECISION + 9);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_FIX, S_SCAN, S_LEN, S_ERR, S_LEAD,
    S_POINT, S_FRAC, S_LETTER, S_SIGN, S_EXPD
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [PREC_W-1:0] prec_r, prec_nxt;
  logic [SPACE_W-1:0]       space_r, space_nxt;
  logic                     zero_r, zero_nxt;
  logic [FW_W-1:0]          cnt_r, cnt_nxt;
  logic [FW_W-1:0]          fracn_r, fracn_nxt;
  logic [FW_W-1:0]          fw_r, fw_nxt;
  logic                     point_r, point_nxt;
  logic                     sign_r, sign_nxt;
  logic [2:0]               ed_r, ed_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]        out_char_r, out_char_nxt;
  logic                     last_r, last_nxt;
  logic                     err_r, err_nxt;

  logic                     accept, adv, is_zero, prec_gt, pt, sg;
  logic [EXPF_W-1:0]        expf;
  logic [FW_W-1:0]          fw;
  logic [2:0]               mind, ed;
  logic [LEN_W-1:0]         len;
  logic [3:0]               lead;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign adv      = !out_valid_r || out_ready;
  assign expf     = value_bits[FRAC_W+EXPF_W-1:FRAC_W];
  assign is_zero  = (value_bits[FRAC_W+EXPF_W-1:0] == '0);
  assign prec     = prec_r;
  assign scan_idx = cnt_r[3:0];

  assign prec_gt = !prec_r[PREC_W-1] && (prec_r[FW_W-1:0] > fracn_r);
  assign fw      = prec_gt ? prec_r[FW_W-1:0] : fracn_r;
  assign pt      = (fw != '0) || cfg.trailing_point;
  assign sg      = exp_st.neg || cfg.plus_sign;
  assign mind    = (cfg.min_exp_digits >= 3'd4) ? 3'd4 :
                   (cfg.min_exp_digits == 3'd0) ? 3'd1 : cfg.min_exp_digits;
  assign ed      = (exp_st.ndig > mind) ? exp_st.ndig : mind;
  assign len     = LEN_W'(2) + LEN_W'(pt) + LEN_W'(fw) + LEN_W'(sg) + LEN_W'(ed);
  assign lead    = (cfg.normalize_mode && !zero_r) ? 4'd1 : frac_st.lead_nib;

  always_comb begin
    state_nxt     = state_r;
    prec_nxt      = prec_r;
    space_nxt     = space_r;
    zero_nxt      = zero_r;
    cnt_nxt       = cnt_r;
    fracn_nxt     = fracn_r;
    fw_nxt        = fw_r;
    point_nxt     = point_r;
    sign_nxt      = sign_r;
    ed_nxt        = ed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    ctl           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.load  = 1'b1;
          zero_nxt  = is_zero;
          space_nxt = space_available;
          if (hex_precision < 0) prec_nxt = -PREC_W'(1);
          else if (hex_precision > PREC_W'(MAX_PRECISION)) prec_nxt = PREC_W'(MAX_PRECISION);
          else prec_nxt = hex_precision;
          if (cfg.normalize_mode && expf == '0 && !is_zero) state_nxt = S_NORM;
          else state_nxt = S_FIX;
        end
      end
      S_NORM: begin
        if (frac_st.lead_set) state_nxt = S_FIX;
        else ctl.norm_step = 1'b1;
      end
      S_FIX: begin
        ctl.fix     = 1'b1;
        ctl.exp_inc = frac_st.carry;
        fracn_nxt   = '0;
        cnt_nxt     = '0;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_r == '0) ctl.dabble_start = 1'b1;
        else if (cnt_r <= FW_W'(MAG_W)) ctl.dabble_step = 1'b1;
        if (frac_st.scan_nib != '0) fracn_nxt = cnt_r + FW_W'(1);
        if (cnt_r == FW_W'(FRAC_NIBS - 1)) state_nxt = S_LEN;
        else cnt_nxt = cnt_r + FW_W'(1);
      end
      S_LEN: begin
        fw_nxt    = fw;
        cnt_nxt   = fw;
        point_nxt = pt;
        sign_nxt  = sg;
        ed_nxt    = ed;
        if (9'(len) > 9'(space_r) || 9'(len) > 9'(MAX_ITEMS)) state_nxt = S_ERR;
        else state_nxt = S_LEAD;
      end
      S_ERR: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          last_nxt      = 1'b1;
          err_nxt       = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LEAD: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = hex_char(lead, cfg.upper_case);
          last_nxt      = 1'b0;
          err_nxt       = 1'b0;
          state_nxt     = point_r ? S_POINT : S_LETTER;
        end
      end
      S_POINT: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = cfg.point_char;
          last_nxt      = 1'b0;
          err_nxt       = 1'b0;
          state_nxt     = (fw_r != '0) ? S_FRAC : S_LETTER;
        end
      end
      S_FRAC: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = hex_char(frac_st.top_nib, cfg.upper_case);
          last_nxt      = 1'b0;
          err_nxt       = 1'b0;
          ctl.nib_shift = 1'b1;
          cnt_nxt       = cnt_r - FW_W'(1);
          if (cnt_r == FW_W'(1)) state_nxt = S_LETTER;
        end
      end
      S_LETTER: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = cfg.exponent_letter;
          last_nxt      = 1'b0;
          err_nxt       = 1'b0;
          cnt_nxt       = FW_W'(ed_r - 3'd1);
          state_nxt     = sign_r ? S_SIGN : S_EXPD;
        end
      end
      S_SIGN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = exp_st.neg ? CH_MINUS : CH_PLUS;
          last_nxt      = 1'b0;
          err_nxt       = 1'b0;
          state_nxt     = S_EXPD;
        end
      end
      S_EXPD: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO + {4'b0, exp_st.bcd[{cnt_r[1:0], 2'b00} +: 4]};
          last_nxt      = (cnt_r == '0);
          err_nxt       = 1'b0;
          cnt_nxt       = cnt_r - FW_W'(1);
          if (cnt_r == '0) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prec_r     <= prec_nxt;
    space_r    <= space_nxt;
    zero_r     <= zero_nxt;
    cnt_r      <= cnt_nxt;
    fracn_r    <= fracn_nxt;
    fw_r       <= fw_nxt;
    point_r    <= point_nxt;
    sign_r     <= sign_nxt;
    ed_r       <= ed_nxt;
    out_char_r <= out_char_nxt;
    last_r     <= last_nxt;
    err_r      <= err_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign last_char = last_r;
  assign no_room   = err_r;

endmodule

>>> hdl/hex_float_formatter_unit.sv
`timescale 1ns / 1ps
// Top level of the hex float formatter: config registers, channels, units.
// Depends on hff_pkg, hff_in_if, hff_out_if, hff_frac_unit, hff_exp_unit, hff_seq.
//
//   port    dir  handshake     payload
//   in_ch   in   valid/ready   value_bits[63:0], hex_precision[6:0] s, space_available[7:0]
//   out_ch  out  valid/ready   out_char[7:0], last_char, no_room
//   cfg_*   in   cfg_we        cfg_index[2:0], cfg_data[7:0]
//
// Per value the sequencer loads it, in normalize mode shifts a subnormal
// left one bit at a time (52 shifts at most), rounds at the precision,
// scans the 13-nibble fraction, sizes the text and then emits n text
// characters (or one error item).
// rst_n is synchronous; no new value is taken until the last item is loaded
// into the output register, and a stalled output holds the sequencer.
module hex_float_formatter_unit import hff_pkg::*; #(
  parameter int MAX_PRECISION = DEF_MAX_PRECISION
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hff_in_if.sink                in_ch,
  hff_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  hff_cfg_t                 cfg_r, cfg_nxt;
  hff_ctl_t                 ctl;
  hff_frac_st_t             frac_st;
  hff_exp_st_t              exp_st;
  logic signed [PREC_W-1:0] prec;
  logic [3:0]               scan_idx;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_UPPER_CASE:      cfg_nxt.upper_case      = cfg_data[0];
        CFG_NORMALIZE_MODE:  cfg_nxt.normalize_mode  = cfg_data[0];
        CFG_TRAILING_POINT:  cfg_nxt.trailing_point  = cfg_data[0];
        CFG_POINT_CHAR:      cfg_nxt.point_char      = cfg_data;
        CFG_EXPONENT_LETTER: cfg_nxt.exponent_letter = cfg_data;
        CFG_MIN_EXP_DIGITS:  cfg_nxt.min_exp_digits  = cfg_data[2:0];
        CFG_PLUS_SIGN:       cfg_nxt.plus_sign       = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_case      <= 1'b0;
      cfg_r.normalize_mode  <= 1'b0;
      cfg_r.trailing_point  <= 1'b0;
      cfg_r.point_char      <= CH_POINT;
      cfg_r.exponent_letter <= CH_LETTER;
      cfg_r.min_exp_digits  <= 3'd1;
      cfg_r.plus_sign       <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hff_frac_unit u_frac (
    .clk            (clk),
    .ctl            (ctl),
    .value_bits     (in_ch.value_bits),
    .normalize_mode (cfg_r.normalize_mode),
    .prec           (prec),
    .scan_idx       (scan_idx),
    .st             (frac_st)
  );

  hff_exp_unit u_exp (
    .clk        (clk),
    .ctl        (ctl),
    .value_bits (in_ch.value_bits),
    .st         (exp_st)
  );

  hff_seq #(
    .MAX_PRECISION (MAX_PRECISION)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .value_bits      (in_ch.value_bits),
    .hex_precision   (in_ch.hex_precision),
    .space_available (in_ch.space_available),
    .ctl             (ctl),
    .prec            (prec),
    .scan_idx        (scan_idx),
    .frac_st         (frac_st),
    .exp_st          (exp_st),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_char        (out_ch.out_char),
    .last_char       (out_ch.last_char),
    .no_room         (out_ch.no_room)
  );

endmodule
